// File: hw/rtl/pbf_pkg.sv
// ----------------------------------------------------------------------------
// pbf_pkg
// Shared types, constants and generator helpers for the packet byte fuzzer.
// ----------------------------------------------------------------------------
package pbf_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 65536;
  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES - 1);

  localparam int unsigned CNT_W = 48;
  localparam int unsigned GEN_W = 32;
  localparam int unsigned ENT_W = 20;
  localparam int unsigned PROT_W = 16;

  localparam logic [GEN_W-1:0] GEN_CONST = 32'd2531011;
  localparam logic [GEN_W-1:0] CASTAGNOLI_REFLECTED = 32'h82F63B78;

  // (gen >> 3) mod PROB_SCALE by reciprocal multiply, one correction step
  localparam logic [ENT_W-1:0] PROB_SCALE = 20'd1000000;
  localparam int unsigned X_W = GEN_W - 3;
  localparam int unsigned RECIP_SH = 40;
  localparam logic [20:0] RECIP = 21'd1099511;
  localparam int unsigned Q_W = 10;
  localparam int unsigned REM_W = ENT_W + 1;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REG_SEED    = 2'd0,
    REG_ENTROPY = 2'd1,
    REG_PROTECT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             was_fuzzed;
    logic             out_last;
    logic [CNT_W-1:0] total_count;
    logic [CNT_W-1:0] fuzzable_count;
    logic [CNT_W-1:0] fuzzed_count;
  } out_rsp_t;

  typedef struct packed {
    logic              seed_load;
    logic [GEN_W-1:0]  seed;
    logic [ENT_W-1:0]  entropy;
    logic [PROT_W-1:0] protect_bytes;
  } cfg_t;

  typedef logic [GEN_W-1:0][GEN_W-1:0] crc_mat_t;

  // 32 reflected crc32c shift steps, used at elaboration only
  function automatic logic [GEN_W-1:0] crc_shift32(input logic [GEN_W-1:0] v);
    logic [GEN_W-1:0] c;
    c = v;
    for (int i = 0; i < GEN_W; i++) begin
      c = c[0] ? ((c >> 1) ^ CASTAGNOLI_REFLECTED) : (c >> 1);
    end
    return c;
  endfunction

  function automatic crc_mat_t crc_cols();
    crc_mat_t m;
    for (int j = 0; j < GEN_W; j++) begin
      m[j] = crc_shift32(GEN_W'(1) << j);
    end
    return m;
  endfunction

  localparam crc_mat_t CRC_MAT = crc_cols();
  localparam logic [GEN_W-1:0] CRC_OFS = crc_shift32(GEN_CONST);

endpackage

// File: hw/rtl/pbf_cfg_regs.sv
// ----------------------------------------------------------------------------
// pbf_cfg_regs
// APB register file holding seed, entropy and protected prefix length.
// ----------------------------------------------------------------------------
module pbf_cfg_regs import pbf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [GEN_W-1:0]  seed_r;
  logic [ENT_W-1:0]  entropy_r;
  logic [PROT_W-1:0] protect_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r    <= '0;
      entropy_r <= '0;
      protect_r <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_SEED:    seed_r    <= pwdata[GEN_W-1:0];
        REG_ENTROPY: entropy_r <= pwdata[ENT_W-1:0];
        REG_PROTECT: protect_r <= pwdata[PROT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SEED:    prdata = seed_r;
      REG_ENTROPY: prdata = DATA_W'(entropy_r);
      REG_PROTECT: prdata = DATA_W'(protect_r);
      default:     prdata = '0;
    endcase
  end

  assign cfg.seed_load     = wr_en && (idx == REG_SEED);
  assign cfg.seed          = pwdata[GEN_W-1:0];
  assign cfg.entropy       = entropy_r;
  assign cfg.protect_bytes = protect_r;

endmodule

// File: hw/rtl/packet_byte_fuzzer.sv
// ----------------------------------------------------------------------------
// packet_byte_fuzzer
// Corrupts packet bytes past a protected prefix with a crc32c driven generator.
// ----------------------------------------------------------------------------
// Takes one byte request per cycle while in_stall is low and returns one result
// per byte, in order, through s1_r, s2_r, s3_r and rsp_r. The generator advances
// by a single XOR network in the accept cycle, so consecutive bytes never wait
// on each other; the probability test (a reciprocal multiply, a multiply back
// and a compare) runs in the three stages behind it. Each stage holds under
// out_stall and frees as soon as its successor moves. Registers must be written
// through the APB port while the block is idle, which it does not enforce. A
// seed write loads the generator at once. No clearing pass is needed after reset.
module packet_byte_fuzzer import pbf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_req_t           in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output out_rsp_t          out_rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             last_byte;
    logic             elig;
    logic [GEN_W-1:0] gen;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] fable;
    logic [Q_W-1:0]   quot;
    logic [REM_W-1:0] rem;
  } st_t;

  cfg_t cfg;

  pbf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic [GEN_W-1:0] gen_r, gen_nxt, gen_step;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] total_r, total_nxt, fable_r, fable_nxt, fzd_r, fzd_nxt;
  logic             v1_r, v2_r, v3_r, vo_r;
  logic             rdy1, rdy2, rdy3, rdyo;
  logic             in_acc, elig;
  st_t              s1_r, s1_nxt, s2_r, s2_nxt, s3_r, s3_nxt;
  out_rsp_t         rsp_r, rsp_nxt;
  logic [X_W+20:0]  prod;
  logic [29:0]      qmul;
  logic [ENT_W-1:0] rem_fix;
  logic             hit;

  assign rdyo     = !vo_r || !out_stall;
  assign rdy3     = !v3_r || rdyo;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign in_acc   = in_valid && rdy1;

  assign out_valid = vo_r;
  assign out_rsp   = rsp_r;

  // accept stage: eligibility, generator step, position and counters
  always_comb begin
    gen_step = CRC_OFS;
    for (int j = 0; j < GEN_W; j++) begin
      if (gen_r[j]) gen_step = gen_step ^ CRC_MAT[j];
    end
    elig = (cfg.entropy != '0) && (pos_r >= cfg.protect_bytes);

    gen_nxt   = gen_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    fable_nxt = fable_r;
    if (in_acc) begin
      total_nxt = total_r + CNT_W'(1);
      if (elig) begin
        gen_nxt   = gen_step;
        fable_nxt = fable_r + CNT_W'(1);
      end
      if (in_req.last_byte) begin
        pos_nxt = '0;
      end else if (pos_r != POS_MAX) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
    if (cfg.seed_load) gen_nxt = cfg.seed;

    s1_nxt           = '0;
    s1_nxt.data_byte = in_req.data_byte;
    s1_nxt.last_byte = in_req.last_byte;
    s1_nxt.elig      = elig;
    s1_nxt.gen       = gen_step;
    s1_nxt.total     = total_nxt;
    s1_nxt.fable     = fable_nxt;
  end

  // reciprocal estimate of the quotient, low by at most one
  always_comb begin
    prod        = s1_r.gen[GEN_W-1:3] * RECIP;
    s2_nxt      = s1_r;
    s2_nxt.quot = prod[RECIP_SH+Q_W-1:RECIP_SH];
  end

  always_comb begin
    qmul       = s2_r.quot * PROB_SCALE;
    s3_nxt     = s2_r;
    s3_nxt.rem = REM_W'({1'b0, s2_r.gen[GEN_W-1:3]} - qmul);
  end

  // remainder correction, probability test and byte corruption
  always_comb begin
    rem_fix = (s3_r.rem >= REM_W'(PROB_SCALE)) ? ENT_W'(s3_r.rem - REM_W'(PROB_SCALE))
                                               : s3_r.rem[ENT_W-1:0];
    hit     = s3_r.elig && (rem_fix < cfg.entropy);
    fzd_nxt = fzd_r;
    if (v3_r && rdyo && hit) fzd_nxt = fzd_r + CNT_W'(1);

    rsp_nxt.out_byte       = hit ? (s3_r.data_byte ^ s3_r.gen[7:0]) : s3_r.data_byte;
    rsp_nxt.was_fuzzed     = hit;
    rsp_nxt.out_last       = s3_r.last_byte;
    rsp_nxt.total_count    = s3_r.total;
    rsp_nxt.fuzzable_count = s3_r.fable;
    rsp_nxt.fuzzed_count   = fzd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r   <= '0;
      pos_r   <= '0;
      total_r <= '0;
      fable_r <= '0;
      fzd_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      vo_r    <= 1'b0;
    end else begin
      gen_r   <= gen_nxt;
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
      fable_r <= fable_nxt;
      fzd_r   <= fzd_nxt;
      if (rdy1) v1_r <= in_acc;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdyo) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s1_r  <= s1_nxt;
    if (rdy2) s2_r  <= s2_nxt;
    if (rdy3) s3_r  <= s3_nxt;
    if (rdyo) rsp_r <= rsp_nxt;
  end

`ifndef SYNTHESIS
  a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cfg.entropy == '0 && !cfg.seed_load) |=> $stable(gen_r))
    else $error("generator moved on a byte with fuzzing disabled");

  a_total_inc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (total_r == CNT_W'($past(total_r) + CNT_W'(1))))
    else $error("total count did not advance on request");

  a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_req.last_byte) |=> (pos_r == '0))
    else $error("position not cleared after last byte");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !rdy3) |-> (vo_r && out_stall))
    else $error("stage three held without a stalled result");
`endif

endmodule
